// ----- src/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int KEY_W        = SAMPLE_WIDTH + 1;
    localparam int MED_W        = SAMPLE_WIDTH + 1;
    localparam int DEV_W        = SAMPLE_WIDTH + 2;

    typedef struct packed {
        logic [31:0] sample;
        logic        present;
        logic        last;
    } request_t;

    typedef struct packed {
        logic [32:0] median_twice;
        logic [33:0] deviation_fourfold;
        logic [6:0]  used_count;
        logic        overflow;
    } result_t;

    typedef struct packed {
        logic lt;
        logic le;
    } cmp_t;

    // pass 0 ranks samples, pass 1 ranks |2x - 2*median|
    function automatic logic [KEY_W-1:0] key_of(
        input logic                    dev_pass,
        input logic [SAMPLE_WIDTH-1:0] x,
        input logic [MED_W-1:0]        med2
    );
        logic [KEY_W-1:0] x2;
        logic [KEY_W-1:0] k;
        x2 = {x, 1'b0};
        if (!dev_pass) begin
            k = {1'b0, x};
        end else if (x2 >= med2) begin
            k = x2 - med2;
        end else begin
            k = med2 - x2;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- src/median_mad_engine.sv -----
`default_nettype none
// an item without last is only stored; busy stays low
// a last item with stored samples sets busy for both rank passes, result_valid rising as busy falls
// empty or overflowed sets give their result in the cycle after the request, no busy time
// cost is set by the single rank comparator: every candidate scans the whole store, twice
// reset clears count, overflow flag and sequencer; store contents are undefined until written
// results cannot be stalled: result_valid is a one-cycle strobe

module median_mad_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mme_pkg::request_t req,
    output logic                   result_valid,
    output mme_pkg::result_t       result
);
    import mme_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CAND   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              pass_reg, pass_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              rvld_reg, rvld_next;
    logic [CNT_W-1:0]  lt_reg, lt_next;
    logic [CNT_W-1:0]  le_reg, le_next;
    logic [KEY_W-1:0]  cand_key_reg, cand_key_next;
    logic [KEY_W-1:0]  lo_key_reg, lo_key_next;
    logic [KEY_W-1:0]  hi_key_reg, hi_key_next;
    logic [MED_W-1:0]  med2_reg, med2_next;
    logic              res_vld_reg, res_vld_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [SAMPLE_WIDTH-1:0] rdata;
    logic [CNT_W-1:0]  n_after;
    logic              ovf_after;
    logic [CNT_W-1:0]  k_lo;
    logic [CNT_W-1:0]  k_hi;
    logic [DEV_W-1:0]  key_sum;
    cmp_t              cmp;

    mme_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req.sample[SAMPLE_WIDTH-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    mme_rank_cmp u_cmp (
        .dev_pass (pass_reg),
        .med2     (med2_reg),
        .cand_key (cand_key_reg),
        .sample   (rdata),
        .cmp      (cmp)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign waddr  = count_reg[ADDR_W-1:0];
    assign k_lo   = (count_reg - CNT_W'(1)) >> 1;
    assign k_hi   = count_reg >> 1;
    assign key_sum = DEV_W'(lo_key_reg) + DEV_W'(hi_key_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pass_next     = pass_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rvld_next     = 1'b0;
        lt_next       = lt_reg;
        le_next       = le_reg;
        cand_key_next = cand_key_reg;
        lo_key_next   = lo_key_reg;
        hi_key_next   = hi_key_reg;
        med2_next     = med2_reg;
        res_vld_next  = 1'b0;
        res_next      = res_reg;
        we            = 1'b0;
        raddr         = i_reg[ADDR_W-1:0];
        n_after       = count_reg;
        ovf_after     = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.present)
                    begin
                        if (count_reg < MAX_CNT)
                        begin
                            we      = 1'b1;
                            n_after = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_after = 1'b1;
                        end
                    end
                    count_next = n_after;
                    ovf_next   = ovf_after;
                    if (req.last)
                    begin
                        if (ovf_after || n_after == '0)
                        begin
                            res_vld_next                = 1'b1;
                            res_next.median_twice       = '0;
                            res_next.deviation_fourfold = '0;
                            res_next.used_count         = 7'(n_after);
                            res_next.overflow           = ovf_after;
                            count_next                  = '0;
                            ovf_next                    = 1'b0;
                        end
                        else
                        begin
                            pass_next  = 1'b0;
                            i_next     = '0;
                            state_next = S_CAND;
                        end
                    end
                end
            end
            S_CAND:
            begin
                raddr      = i_reg[ADDR_W-1:0];
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cand_key_next = key_of(pass_reg, rdata, med2_reg);
                j_next        = '0;
                lt_next       = '0;
                le_next       = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                raddr = j_reg[ADDR_W-1:0];
                if (j_reg < count_reg)
                begin
                    j_next    = j_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                end
                if (rvld_reg)
                begin
                    lt_next = lt_reg + CNT_W'(cmp.lt);
                    le_next = le_reg + CNT_W'(cmp.le);
                end
                if (j_reg == count_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // candidate covers sorted positions lt .. le-1
                if (lt_reg <= k_lo && k_lo < le_reg)
                begin
                    lo_key_next = cand_key_reg;
                end
                if (lt_reg <= k_hi && k_hi < le_reg)
                begin
                    hi_key_next = cand_key_reg;
                end
                i_next = i_reg + CNT_W'(1);
                if (i_next == count_reg)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_CAND;
                end
            end
            S_SUM:
            begin
                if (!pass_reg)
                begin
                    med2_next  = key_sum[MED_W-1:0];
                    pass_next  = 1'b1;
                    i_next     = '0;
                    state_next = S_CAND;
                end
                else
                begin
                    res_vld_next                = 1'b1;
                    res_next.median_twice       = med2_reg;
                    res_next.deviation_fourfold = key_sum;
                    res_next.used_count         = 7'(count_reg);
                    res_next.overflow           = 1'b0;
                    count_next                  = '0;
                    ovf_next                    = 1'b0;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            pass_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            rvld_reg    <= 1'b0;
            lt_reg      <= '0;
            le_reg      <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pass_reg    <= pass_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            rvld_reg    <= rvld_next;
            lt_reg      <= lt_next;
            le_reg      <= le_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_key_reg <= cand_key_next;
        lo_key_reg   <= lo_key_next;
        hi_key_reg   <= hi_key_next;
        med2_reg     <= med2_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.overflow) |->
            (result.median_twice == '0 && result.deviation_fourfold == '0))
        else $error("overflowed set gave nonzero statistics");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("stored count beyond store depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg <= count_reg && count_reg != '0))
        else $error("scan index beyond stored count");

    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (count_reg == '0 && !ovf_reg) || $past(accept))
        else $error("set not cleared after result");

endmodule

`default_nettype wire

// ----- src/mme_ram.sv -----
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/mme_rank_cmp.sv -----
`default_nettype none

module mme_rank_cmp (
    input  wire logic                             dev_pass,
    input  wire logic [mme_pkg::MED_W-1:0]        med2,
    input  wire logic [mme_pkg::KEY_W-1:0]        cand_key,
    input  wire logic [mme_pkg::SAMPLE_WIDTH-1:0] sample,
    output mme_pkg::cmp_t                         cmp
);
    import mme_pkg::*;

    logic [KEY_W-1:0] other_key;

    always_comb
    begin
        other_key = key_of(dev_pass, sample, med2);
        cmp.lt    = other_key < cand_key;
        cmp.le    = other_key <= cand_key;
    end

endmodule

`default_nettype wire
